// ===== sv/nec_pkg.sv =====
// ----------------------------------------------------------------------------
// nec_pkg
// Types, widths and constants shared by the note event coalescer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nec_pkg;

    // Field widths.
    localparam int NOTE_W  = 8;
    localparam int FRAME_W = 32;
    localparam int LEVEL_W = 16;

    // Weighted-mean arithmetic: level times frame count, sum of two such
    // products, and the sum of two frame counts.
    localparam int PROD_W = LEVEL_W + FRAME_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DEN_W  = FRAME_W + 1;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = LEVEL_W;

    // Default queue depths.
    localparam int WORK_DEPTH_DEFAULT   = 4;
    localparam int RESULT_DEPTH_DEFAULT = 2;

    // Note number that marks a rest.
    localparam logic signed [NOTE_W-1:0] REST_NOTE = -8'sd1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VOLUME_THRESHOLD = 1'd0,
        CFG_DUTY_THRESHOLD   = 1'd1
    } t_cfg_index;

    // One input item as it arrives.
    typedef struct packed {
        logic                      segment_active;
        logic signed [NOTE_W-1:0]  midi_note;
        logic [FRAME_W-1:0]        frame_start;
        logic [FRAME_W-1:0]        frame_end;
        logic [FRAME_W-1:0]        sample_start;
        logic [FRAME_W-1:0]        sample_end;
        logic [LEVEL_W-1:0]        volume_level;
        logic [LEVEL_W-1:0]        duty_level;
        logic                      last_segment;
    } t_segment;

    // One result item.
    typedef struct packed {
        logic                      note_active;
        logic signed [NOTE_W-1:0]  note_number;
        logic [FRAME_W-1:0]        event_frame_start;
        logic [FRAME_W-1:0]        event_frame_end;
        logic [FRAME_W-1:0]        event_sample_start;
        logic [FRAME_W-1:0]        event_sample_end;
        logic [LEVEL_W-1:0]        event_volume;
        logic [LEVEL_W-1:0]        event_duty;
        logic                      last_event;
    } t_event;

    // A classified segment as it waits between front and back.
    typedef struct packed {
        logic                      active;
        logic signed [NOTE_W-1:0]  note;
        logic [FRAME_W-1:0]        frame_start;
        logic [FRAME_W-1:0]        frame_end;
        logic [FRAME_W-1:0]        sample_start;
        logic [FRAME_W-1:0]        sample_end;
        logic [LEVEL_W-1:0]        volume;
        logic [LEVEL_W-1:0]        duty;
        logic                      last;
        logic [FRAME_W-1:0]        frame_count;
    } t_work;

    // Request from the back end to the divider.
    typedef struct packed {
        logic                      start;
        logic [NUM_W-1:0]          numerator;
        logic [DEN_W-1:0]          denominator;
    } t_div_req;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_MUL0,
        S_MUL1,
        S_SUM,
        S_DIV_WAIT,
        S_EMIT_OLD,
        S_LAST
    } t_state;

endpackage

// ===== sv/nec_fifo.sv =====
// ----------------------------------------------------------------------------
// nec_fifo
// Small synchronous queue of fixed-width items, head shown combinationally.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CNT_W'(push_ok) - CNT_W'(pop_ok);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/nec_front.sv =====
// ----------------------------------------------------------------------------
// nec_front
// Accepts segments and classifies each one as a note or a rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_front (
    input  logic              push,
    output logic              full,
    input  nec_pkg::t_segment i_segment,
    output logic              o_wq_push,
    output nec_pkg::t_work    o_wq_data,
    input  logic              i_wq_full
);

    import nec_pkg::*;

    logic is_note;

    // A segment sounds only when it is marked active and its note is not negative.
    assign is_note = i_segment.segment_active && !i_segment.midi_note[NOTE_W-1];

    // Rests carry the rest note and zero levels.
    always_comb begin
        o_wq_data.active       = is_note;
        o_wq_data.note         = is_note ? i_segment.midi_note : REST_NOTE;
        o_wq_data.frame_start  = i_segment.frame_start;
        o_wq_data.frame_end    = i_segment.frame_end;
        o_wq_data.sample_start = i_segment.sample_start;
        o_wq_data.sample_end   = i_segment.sample_end;
        o_wq_data.volume       = is_note ? i_segment.volume_level : '0;
        o_wq_data.duty         = is_note ? i_segment.duty_level : '0;
        o_wq_data.last         = i_segment.last_segment;
        o_wq_data.frame_count  = i_segment.frame_end - i_segment.frame_start;
    end

    // The work queue sets the input handshake.
    assign full      = i_wq_full;
    assign o_wq_push = push && !i_wq_full;

endmodule

// ===== sv/nec_divider.sv =====
// ----------------------------------------------------------------------------
// nec_divider
// Restoring divider that yields a 16-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  nec_pkg::t_div_req          i_req,
    output logic                       o_done,
    output logic [nec_pkg::LEVEL_W-1:0] o_quotient
);

    import nec_pkg::*;

    localparam int CNT_W = $clog2(LEVEL_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [LEVEL_W-1:0] r_low;
    logic [LEVEL_W-1:0] r_quo;
    logic [DEN_W:0]     shifted;
    logic [DEN_W:0]     diff;
    logic               fits;

    // The quotient is known to fit in 16 bits, so the upper numerator bits
    // start out as the partial remainder.
    assign shifted = {r_rem, r_low[r_cnt]};
    assign diff    = shifted - {1'b0, r_den};
    assign fits    = (shifted >= {1'b0, r_den});

    // Control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // One quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.numerator[NUM_W-1:LEVEL_W];
            r_low <= i_req.numerator[LEVEL_W-1:0];
            r_den <= i_req.denominator;
            r_cnt <= CNT_W'(LEVEL_W - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= diff[DEN_W-1:0];
            end else begin
                r_rem <= shifted[DEN_W-1:0];
            end
            r_quo <= {r_quo[LEVEL_W-2:0], fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/nec_back.sv =====
// ----------------------------------------------------------------------------
// nec_back
// Holds the open event, merges or emits it, and forms weighted means.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nec_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_wq_empty,
    input  nec_pkg::t_work                  i_wq_data,
    output logic                            o_wq_pop,
    output logic                            o_res_push,
    output nec_pkg::t_event                 o_res_data,
    input  logic                            i_res_full,
    output nec_pkg::t_div_req               o_div_req,
    input  logic                            i_div_done,
    input  logic [nec_pkg::LEVEL_W-1:0]     i_div_quotient
);

    import nec_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_work              r_item;
    t_event             r_held;
    logic               r_held_valid;
    logic [LEVEL_W-1:0] r_vol_thr;
    logic [LEVEL_W-1:0] r_duty_thr;
    logic [FRAME_W-1:0] r_lf;
    logic [DEN_W-1:0]   r_tot;
    logic               r_sel;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  r_num;

    logic [FRAME_W-1:0] lf;
    logic [DEN_W-1:0]   tot;
    logic [LEVEL_W-1:0] vol_diff;
    logic [LEVEL_W-1:0] duty_diff;
    logic               merge;
    t_event             new_event;
    logic [LEVEL_W-1:0] mul_a;
    logic [FRAME_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;

    // Frame counts of the held event and the total over both.
    assign lf  = r_held.event_frame_end - r_held.event_frame_start;
    assign tot = {1'b0, lf} + {1'b0, r_item.frame_count};

    // Level differences against the held event.
    assign vol_diff  = (r_held.event_volume >= r_item.volume) ?
                       r_held.event_volume - r_item.volume :
                       r_item.volume - r_held.event_volume;
    assign duty_diff = (r_held.event_duty >= r_item.duty) ?
                       r_held.event_duty - r_item.duty :
                       r_item.duty - r_held.event_duty;

    // Merge when contiguous and either both rests or the same note at close levels.
    always_comb begin
        merge = 1'b0;
        if (r_held_valid && r_held.event_frame_end == r_item.frame_start) begin
            if (!r_held.note_active && !r_item.active) begin
                merge = 1'b1;
            end else if (r_held.note_active && r_item.active &&
                         r_held.note_number == r_item.note &&
                         vol_diff <= r_vol_thr && duty_diff <= r_duty_thr) begin
                merge = 1'b1;
            end
        end
    end

    // The event that a non-merging segment opens.
    always_comb begin
        new_event.note_active        = r_item.active;
        new_event.note_number        = r_item.note;
        new_event.event_frame_start  = r_item.frame_start;
        new_event.event_frame_end    = r_item.frame_end;
        new_event.event_sample_start = r_item.sample_start;
        new_event.event_sample_end   = r_item.sample_end;
        new_event.event_volume       = r_item.volume;
        new_event.event_duty         = r_item.duty;
        new_event.last_event         = 1'b0;
    end

    // Shared multiplier: held level by held count, then new level by new count.
    always_comb begin
        if (r_state == S_MUL0) begin
            mul_a = r_sel ? r_held.event_duty : r_held.event_volume;
            mul_b = r_lf;
        end else begin
            mul_a = r_sel ? r_item.duty : r_item.volume;
            mul_b = r_item.frame_count;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Divider request: sum of the two products over the total frame count.
    always_comb begin
        o_div_req.start       = (r_state == S_SUM);
        o_div_req.numerator   = {1'b0, r_num} + {1'b0, r_prod};
        o_div_req.denominator = r_tot;
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and handshakes.
    always_comb begin
        n_state               = r_state;
        o_wq_pop              = 1'b0;
        o_res_push            = 1'b0;
        o_res_data            = r_held;
        o_res_data.last_event = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_wq_empty) begin
                    o_wq_pop = 1'b1;
                    n_state  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (merge) begin
                    n_state = (r_held.note_active && tot != '0) ? S_MUL0 : S_LAST;
                end else if (r_held_valid) begin
                    n_state = S_EMIT_OLD;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_MUL0: begin
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_div_done) begin
                    n_state = r_sel ? S_LAST : S_MUL0;
                end
            end
            S_EMIT_OLD: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_LAST;
                end
            end
            S_LAST: begin
                if (!r_item.last) begin
                    n_state = S_IDLE;
                end else if (!i_res_full) begin
                    o_res_push            = 1'b1;
                    o_res_data.last_event = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration registers and the held-event flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_vol_thr    <= '0;
            r_duty_thr   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_VOLUME_THRESHOLD: r_vol_thr  <= i_cfg_data;
                    CFG_DUTY_THRESHOLD:   r_duty_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DECIDE && !merge) begin
                r_held_valid <= 1'b1;
            end else if (r_state == S_LAST && r_item.last && !i_res_full) begin
                r_held_valid <= 1'b0;
            end
        end
    end

    // Item, held event and arithmetic registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (!i_wq_empty) begin
                    r_item <= i_wq_data;
                end
            end
            S_DECIDE: begin
                r_lf  <= lf;
                r_tot <= tot;
                r_sel <= 1'b0;
                if (merge) begin
                    r_held.event_frame_end  <= r_item.frame_end;
                    r_held.event_sample_end <= r_item.sample_end;
                end else if (!r_held_valid) begin
                    r_held <= new_event;
                end
            end
            S_MUL0: begin
                r_prod <= mul_p;
            end
            S_MUL1: begin
                r_num  <= r_prod;
                r_prod <= mul_p;
            end
            S_DIV_WAIT: begin
                if (i_div_done) begin
                    if (r_sel) begin
                        r_held.event_duty <= i_div_quotient;
                    end else begin
                        r_held.event_volume <= i_div_quotient;
                    end
                    r_sel <= 1'b1;
                end
            end
            S_EMIT_OLD: begin
                if (!i_res_full) begin
                    r_held <= new_event;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== sv/note_event_coalescer.sv =====
// ----------------------------------------------------------------------------
// note_event_coalescer
// Merges analysed segments into note and rest events.
//
// Segments enter through a queue-like port (push, full) and events leave
// through another (empty, pop); a work queue between the classifying front
// end and the merging back end lets each side stall on its own. The two
// merge thresholds are written through i_cfg_we, i_cfg_index and i_cfg_data
// by the user, only while the block is idle; the block does not enforce it.
// The back end handles one item at a time. A merge of two notes uses the
// one shared multiplier and the 16-step divider, which run once for volume
// and once for duty. The first result of a segment, if any, enters the
// result queue after the back end pops the segment, and after a note merge
// only once both means are formed.
// Reset clears both queues, the open event and the thresholds; after reset
// full is low and empty is high. When the receiver stops popping, the result
// queue fills, the back end waits, then the work queue fills and full rises;
// nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module note_event_coalescer #(
    parameter int WORK_DEPTH   = nec_pkg::WORK_DEPTH_DEFAULT,
    parameter int RESULT_DEPTH = nec_pkg::RESULT_DEPTH_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [nec_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [nec_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  nec_pkg::t_segment               i_segment,
    output logic                            empty,
    input  logic                            pop,
    output nec_pkg::t_event                 o_event
);

    import nec_pkg::*;

    logic                     wq_push;
    t_work                    wq_in;
    logic                     wq_full;
    logic                     wq_pop;
    logic                     wq_empty;
    logic [$bits(t_work)-1:0] wq_out;
    logic                     res_push;
    t_event                   res_in;
    logic                     res_full;
    logic [$bits(t_event)-1:0] res_out;
    t_div_req                 div_req;
    logic                     div_done;
    logic [LEVEL_W-1:0]       div_quotient;

    // Classification of incoming segments.
    nec_front u_front (
        .push      (push),
        .full      (full),
        .i_segment (i_segment),
        .o_wq_push (wq_push),
        .o_wq_data (wq_in),
        .i_wq_full (wq_full)
    );

    // Classified segments waiting for the back end.
    nec_fifo #(
        .WIDTH ($bits(t_work)),
        .DEPTH (WORK_DEPTH)
    ) u_work_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wq_push),
        .i_data  (wq_in),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_empty (wq_empty),
        .o_data  (wq_out)
    );

    // Merging and emission.
    nec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_wq_empty     (wq_empty),
        .i_wq_data      (t_work'(wq_out)),
        .o_wq_pop       (wq_pop),
        .o_res_push     (res_push),
        .o_res_data     (res_in),
        .i_res_full     (res_full),
        .o_div_req      (div_req),
        .i_div_done     (div_done),
        .i_div_quotient (div_quotient)
    );

    // Weighted-mean divider.
    nec_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Events waiting for the receiver.
    nec_fifo #(
        .WIDTH ($bits(t_event)),
        .DEPTH (RESULT_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign o_event = t_event'(res_out);

endmodule

// ===== sv/nec_checker.sv =====
// ----------------------------------------------------------------------------
// nec_checker
// Port-level checks on the note event coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nec_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            full,
    input logic                            empty,
    input logic                            pop,
    input nec_pkg::t_event                 o_event
);

    import nec_pkg::*;

    // Leaving reset, both queues are empty.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

    // A rest event carries the rest note and zero levels.
    a_rest_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_event.note_active) |->
        (o_event.note_number == REST_NOTE && o_event.event_volume == '0 &&
         o_event.event_duty == '0))
        else $error("rest event with note or level set");

    // A note event never carries a negative note.
    a_note_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_event.note_active) |-> !o_event.note_number[NOTE_W-1])
        else $error("note event with negative note");

    // A waiting item that is not taken stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_event)))
        else $error("waiting item changed or vanished");

endmodule

bind note_event_coalescer nec_checker u_checker (.*);

// ===== dv/note_event_coalescer_test.sv =====
// ----------------------------------------------------------------------------
// note_event_coalescer_test
// Self-checking testbench for the note event coalescer.
//
// Segment items are pushed through the input queue port. A scoreboard keeps
// its own copy of the open event and both merge thresholds. It predicts the
// events that each accepted item releases, and it compares every popped event
// field by field against the oldest prediction. A short directed sequence
// covers rests, merges, frame wrap and zero-length averaging. Three random
// phases follow, each with its own thresholds and its own idle pattern on the
// sending and receiving sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module note_event_coalescer_test;
    import nec_pkg::*;

    // Cycles to let a queued run of note merges finish after the last event.
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASE_ITEMS   = 160;

    // Predicts released events and checks the ones the block hands out.
    class segment_scoreboard;
        logic [LEVEL_W-1:0] volume_threshold = '0;
        logic [LEVEL_W-1:0] duty_threshold   = '0;
        logic               open_valid       = 1'b0;
        t_event             open_event       = '0;
        t_event             expected_events[$];
        int                 errors           = 0;
        int                 events_checked   = 0;
        int                 merges           = 0;

        function void set_threshold(t_cfg_index index, logic [LEVEL_W-1:0] value);
            case (index)
                CFG_VOLUME_THRESHOLD: volume_threshold = value;
                CFG_DUTY_THRESHOLD:   duty_threshold = value;
                default: ;
            endcase
        endfunction

        function logic [LEVEL_W-1:0] level_gap(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        // Updates the open event with one accepted segment item.
        function void note_segment(t_segment seg);
            logic        act;
            logic        joins;
            t_event      incoming;
            logic [63:0] open_len;
            logic [63:0] new_len;
            logic [63:0] total;
            logic [63:0] mean;

            act = seg.segment_active && !seg.midi_note[NOTE_W-1];
            incoming = '0;
            incoming.note_active        = act;
            incoming.note_number        = act ? seg.midi_note : REST_NOTE;
            incoming.event_frame_start  = seg.frame_start;
            incoming.event_frame_end    = seg.frame_end;
            incoming.event_sample_start = seg.sample_start;
            incoming.event_sample_end   = seg.sample_end;
            incoming.event_volume       = act ? seg.volume_level : '0;
            incoming.event_duty         = act ? seg.duty_level : '0;

            // Only an item that starts where the open event ends may join it.
            joins = 1'b0;
            if (open_valid && open_event.event_frame_end == seg.frame_start) begin
                if (!open_event.note_active && !act) begin
                    joins = 1'b1;
                end else if (open_event.note_active && act &&
                             open_event.note_number == incoming.note_number &&
                             level_gap(open_event.event_volume, incoming.event_volume)
                                 <= volume_threshold &&
                             level_gap(open_event.event_duty, incoming.event_duty)
                                 <= duty_threshold) begin
                    joins = 1'b1;
                end
            end

            if (joins) begin
                merges++;
                open_len = {32'd0, open_event.event_frame_end - open_event.event_frame_start};
                new_len  = {32'd0, seg.frame_end - seg.frame_start};
                total    = open_len + new_len;
                // Frame-weighted means; a zero total leaves the levels alone.
                if (open_event.note_active && total != 0) begin
                    mean = ({48'd0, open_event.event_volume} * open_len +
                            {48'd0, incoming.event_volume} * new_len) / total;
                    open_event.event_volume = mean[LEVEL_W-1:0];
                    mean = ({48'd0, open_event.event_duty} * open_len +
                            {48'd0, incoming.event_duty} * new_len) / total;
                    open_event.event_duty = mean[LEVEL_W-1:0];
                end
                open_event.event_frame_end  = seg.frame_end;
                open_event.event_sample_end = seg.sample_end;
            end else begin
                if (open_valid) begin
                    expected_events.push_back(open_event);
                end
                open_event = incoming;
                open_valid = 1'b1;
            end

            // The last segment flushes whatever is open.
            if (seg.last_segment) begin
                open_event.last_event = 1'b1;
                expected_events.push_back(open_event);
                open_valid = 1'b0;
                open_event = '0;
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t ns: %s expected %h, got %h", $time, field, want, got);
            end
        endfunction

        // Checks one popped event against the oldest prediction.
        function void check_event(t_event got);
            t_event want;

            if (expected_events.size() == 0) begin
                errors++;
                $display("%0t ns: event with none expected, got %h", $time, got);
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            compare_field("note_active", {31'd0, want.note_active}, {31'd0, got.note_active});
            compare_field("note_number", {24'd0, want.note_number}, {24'd0, got.note_number});
            compare_field("event_frame_start", want.event_frame_start, got.event_frame_start);
            compare_field("event_frame_end", want.event_frame_end, got.event_frame_end);
            compare_field("event_sample_start", want.event_sample_start,
                          got.event_sample_start);
            compare_field("event_sample_end", want.event_sample_end, got.event_sample_end);
            compare_field("event_volume", {16'd0, want.event_volume},
                          {16'd0, got.event_volume});
            compare_field("event_duty", {16'd0, want.event_duty}, {16'd0, got.event_duty});
            compare_field("last_event", {31'd0, want.last_event}, {31'd0, got.last_event});
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   push        = 1'b0;
    logic                   full;
    t_segment               i_segment   = '0;
    logic                   empty;
    logic                   pop         = 1'b0;
    t_event                 o_event;

    segment_scoreboard sb = new;

    int send_idle_pct = 17;
    int recv_idle_pct = 49;
    int items_sent    = 0;
    int settings_used = 1;

    // State of the random segment stream, so that most items line up.
    logic [FRAME_W-1:0]       frame_cursor  = '0;
    logic [FRAME_W-1:0]       sample_cursor = '0;
    logic signed [NOTE_W-1:0] recent_note   = 8'sd60;
    logic [LEVEL_W-1:0]       recent_volume = 16'h8000;
    logic [LEVEL_W-1:0]       recent_duty   = 16'h4000;

    note_event_coalescer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_segment   (i_segment),
        .empty       (empty),
        .pop         (pop),
        .o_event     (o_event)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: pops at random and checks every event it takes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                sb.check_event(o_event);
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Runaway guard.
    initial begin
        #2_000_000;
        $display("note_event_coalescer_test NOT OK");
        $finish;
    end

    function automatic t_segment make_segment(int act, int note,
                                              logic [31:0] fs, logic [31:0] fe,
                                              logic [31:0] ss, logic [31:0] se,
                                              logic [15:0] vol, logic [15:0] duty,
                                              int last);
        t_segment seg;

        seg.segment_active = (act != 0);
        seg.midi_note      = note[NOTE_W-1:0];
        seg.frame_start    = fs;
        seg.frame_end      = fe;
        seg.sample_start   = ss;
        seg.sample_end     = se;
        seg.volume_level   = vol;
        seg.duty_level     = duty;
        seg.last_segment   = (last != 0);
        return seg;
    endfunction

    // Next level: often the same, often close, sometimes anything.
    function automatic logic [LEVEL_W-1:0] next_level(logic [LEVEL_W-1:0] prev);
        int          pick;
        logic [15:0] step;

        pick = $urandom_range(99);
        step = 16'($urandom_range(0, 512));
        if (pick < 40) begin
            return prev;
        end else if (pick < 75) begin
            return prev + step - 16'd256;
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly back-to-back segments of the same note; the rest is noise.
    function automatic t_segment random_segment();
        t_segment           seg;
        int                 pick;
        logic [FRAME_W-1:0] length;

        seg = '0;
        seg.segment_active = ($urandom_range(9) != 0);
        pick = $urandom_range(0, 128);
        if ($urandom_range(99) < 80) begin
            seg.midi_note = recent_note;
        end else begin
            seg.midi_note = (pick == 128) ? REST_NOTE : pick[NOTE_W-1:0];
        end

        pick = $urandom_range(99);
        if (pick < 70) begin
            length = $urandom_range(0, 16);
        end else if (pick < 95) begin
            length = $urandom_range(0, 4000);
        end else begin
            length = $urandom;
        end
        seg.frame_start = ($urandom_range(99) < 85) ? frame_cursor : $urandom;
        seg.frame_end   = seg.frame_start + length;

        if ($urandom_range(99) < 80) begin
            seg.sample_start = sample_cursor;
            seg.sample_end   = sample_cursor + $urandom_range(0, 5000);
        end else begin
            seg.sample_start = $urandom;
            seg.sample_end   = $urandom;
        end

        seg.volume_level = next_level(recent_volume);
        seg.duty_level   = next_level(recent_duty);
        seg.last_segment = ($urandom_range(99) < 4);

        frame_cursor  = seg.frame_end;
        sample_cursor = seg.sample_end;
        recent_note   = seg.midi_note;
        recent_volume = seg.volume_level;
        recent_duty   = seg.duty_level;
        return seg;
    endfunction

    // Pushes one segment item, idling first at the current rate.
    task automatic send_segment(input t_segment seg);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_segment <= seg;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sb.note_segment(seg);
        items_sent++;
    endtask

    // Stops sending until every predicted event is out, then settles.
    task automatic hold_until_drained(input int settle);
        push <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.pending() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Writes both thresholds back to back, volume first, then duty.
    task automatic write_thresholds(input logic [LEVEL_W-1:0] vol_thr,
                                    input logic [LEVEL_W-1:0] duty_thr);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_VOLUME_THRESHOLD;
        i_cfg_data  <= vol_thr;
        @(posedge i_clk);
        sb.set_threshold(CFG_VOLUME_THRESHOLD, vol_thr);
        i_cfg_index <= CFG_DUTY_THRESHOLD;
        i_cfg_data  <= duty_thr;
        @(posedge i_clk);
        sb.set_threshold(CFG_DUTY_THRESHOLD, duty_thr);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct,
                             input logic [LEVEL_W-1:0] vol_thr,
                             input logic [LEVEL_W-1:0] duty_thr);
        t_segment seg;

        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        write_thresholds(vol_thr, duty_thr);
        settings_used++;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            seg = random_segment();
            if (n == PHASE_ITEMS - 1) begin
                seg.last_segment = 1'b1;
            end
            send_segment(seg);
            // Let the block run completely dry once in the middle.
            if (n == PHASE_ITEMS / 2) begin
                hold_until_drained(0);
            end
        end
        hold_until_drained(SETTLE_CYCLES);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items with the thresholds at their reset value of zero.
        send_segment(make_segment(1, 60, 0, 10, 0, 100, 16'h8000, 16'h4000, 0));
        send_segment(make_segment(1, 60, 10, 20, 100, 200, 16'h8000, 16'h4000, 0));
        send_segment(make_segment(1, 60, 20, 30, 200, 300, 16'h8001, 16'h4000, 0));
        send_segment(make_segment(1, 60, 30, 40, 300, 400, 16'h8001, 16'h4001, 0));
        send_segment(make_segment(1, 61, 40, 50, 400, 500, 16'h8001, 16'h4001, 0));
        // Inactive item and negative note both become rests, which then merge.
        send_segment(make_segment(0, 61, 50, 60, 500, 600, 16'hFFFF, 16'hFFFF, 0));
        send_segment(make_segment(1, -1, 60, 70, 600, 700, 16'h1234, 16'h5678, 0));
        send_segment(make_segment(0, -1, 71, 80, 710, 800, 16'h0000, 16'h0000, 0));
        // Two zero-length notes merge with a zero frame total.
        send_segment(make_segment(1, 127, 80, 80, 800, 800, 16'h0000, 16'h0000, 0));
        send_segment(make_segment(1, 127, 80, 80, 800, 800, 16'h0000, 16'h0000, 0));
        // Last item that does not merge releases two events.
        send_segment(make_segment(1, 0, 80, 90, 800, 900, 16'hFFFF, 16'hFFFF, 1));
        send_segment(make_segment(1, 0, 0, 5, 0, 50, 16'h0001, 16'h0001, 1));
        send_segment(make_segment(0, 5, 5, 9, 50, 90, 16'h0000, 16'h0000, 0));
        send_segment(make_segment(0, 5, 9, 12, 90, 120, 16'h0000, 16'h0000, 1));
        hold_until_drained(SETTLE_CYCLES);

        // Directed averaging with the widest thresholds and wrapping frames.
        write_thresholds(16'hFFFF, 16'hFFFF);
        settings_used++;
        send_segment(make_segment(1, 127, 32'hFFFF_FFF0, 32'h0000_0010, 32'h0,
                                  32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 0));
        send_segment(make_segment(1, 127, 32'h0000_0010, 32'h0000_000F, 32'hFFFF_FFFF,
                                  32'h0, 16'h0000, 16'hFFFF, 0));
        send_segment(make_segment(1, 127, 32'h0000_000F, 32'h0000_000F, 32'h0,
                                  32'h1, 16'h1234, 16'hABCD, 0));
        send_segment(make_segment(1, 5, 200, 200, 2000, 2000, 16'h1000, 16'h2000, 0));
        send_segment(make_segment(1, 5, 200, 200, 2000, 2000, 16'h9000, 16'h7000, 1));
        send_segment(make_segment(1, 64, 300, 400, 3000, 4000, 16'hFFFF, 16'hFFFF, 0));
        send_segment(make_segment(1, 64, 400, 500, 4000, 5000, 16'h0000, 16'h0000, 1));
        hold_until_drained(SETTLE_CYCLES);

        // Random phases: receiver then sender idles more, then neither does.
        run_phase(17, 49, 16'($urandom_range(16'h0100, 16'h1000)),
                  16'($urandom_range(16'h0100, 16'h1000)));
        run_phase(49, 17, 16'hFFFF, 16'h0000);
        run_phase(0, 0, 16'h0000, 16'hFFFF);

        $display("Covered %0d segment items under %0d threshold settings.",
                 items_sent, settings_used);
        $display("Checked %0d events; %0d merges were predicted.",
                 sb.events_checked, sb.merges);
        if (sb.errors == 0) begin
            $display("note_event_coalescer_test OK");
        end else begin
            $display("note_event_coalescer_test NOT OK");
        end
        $finish;
    end

endmodule
